FILE: design/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rpvr_pkg.sv
package rpvr_pkg;

    // Angle and vector formats
    localparam int FRAC_BITS = 16;
    localparam int LON_W     = 25;
    localparam int LAT_W     = 24;
    localparam int VEC_W     = 32;

    // Degree to phase conversion
    localparam int DEG_W  = 26;
    localparam int TURN_W = 25;
    localparam logic signed [DEG_W-1:0] FULL_TURN = 26'sd23592960; // 360 << FRAC_BITS
    localparam int RECIP_SHIFT = 31;
    localparam logic [25:0] RECIP_45 = 26'd47721859;              // ceil(2^31 / 45)
    localparam logic [TURN_W-1:0] DIV_45 = 25'd45;
    localparam int Q_W   = 19;
    localparam int LOW_W = 13;
    localparam int REM_W = 6;
    localparam logic [LOW_W-1:0] LOW_STEP  = 13'd182;             // 8192 / 45, integer part
    localparam logic [REM_W-1:0] LOW_KNEE1 = 6'd12;
    localparam logic [REM_W-1:0] LOW_KNEE2 = 6'd34;
    localparam int PHASE_W = 32;

    // CORDIC
    localparam int ITERS = 24;
    localparam int CW    = 33;
    localparam int ZW    = 34;
    localparam int SCW   = 32;
    localparam int VW    = 35;
    localparam int AB_W  = 34;
    localparam logic signed [CW-1:0] INV_GAIN = 33'sd652032874;
    localparam logic [PHASE_W-1:0] ATAN_TAB [0:ITERS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLE_LON = 2'd0,
        REG_POLE_LAT = 2'd1
    } cfg_reg_t;
    localparam logic signed [LON_W-1:0] POLE_LON_RST = 25'sd983040;
    localparam logic signed [LAT_W-1:0] POLE_LAT_RST = 24'sd2621440;

    // Pipeline stage numbers (stage k is the k-th register a beat passes through)
    localparam int ST_TRIG = 29;
    localparam int ST_AB   = 32;
    localparam int ST_V0   = 33;
    localparam int ST_SC2  = 83;
    localparam int ST_LAST = 84;

    typedef struct packed {
        logic                    kind;
        logic [VEC_W-1:0]        u;
        logic [VEC_W-1:0]        v;
    } side_t;

endpackage

FILE: design/rpvr_if.sv
interface rpvr_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [rpvr_pkg::LON_W-1:0]   lon_deg;
    logic signed [rpvr_pkg::LAT_W-1:0]   lat_deg;
    logic signed [rpvr_pkg::VEC_W-1:0]   u_in;
    logic signed [rpvr_pkg::VEC_W-1:0]   v_in;

    modport source (output valid, kind, lon_deg, lat_deg, u_in, v_in, input ready);
    modport sink   (input valid, kind, lon_deg, lat_deg, u_in, v_in, output ready);
endinterface

interface rpvr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rpvr_pkg::VEC_W-1:0]   u_out;
    logic signed [rpvr_pkg::VEC_W-1:0]   v_out;
    logic                                degenerate;

    modport source (output valid, u_out, v_out, degenerate, input ready);
    modport sink   (input valid, u_out, v_out, degenerate, output ready);
endinterface

interface rpvr_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [rpvr_pkg::CFG_IDX_W-1:0]        index;
    logic [rpvr_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/rpvr_phase.sv
module rpvr_phase (
    input  logic                                   clk,
    input  logic                                   adv,
    input  logic signed [rpvr_pkg::DEG_W-1:0]      deg,
    output logic [rpvr_pkg::PHASE_W-1:0]           phase
);

    logic signed [rpvr_pkg::DEG_W-1:0]  s1;
    logic signed [rpvr_pkg::DEG_W-1:0]  s2;
    logic [rpvr_pkg::TURN_W-1:0]        r_reg;
    logic [rpvr_pkg::TURN_W-1:0]        r2_reg;
    logic [50:0]                        prod_next;
    logic [50:0]                        prod_reg;
    logic [rpvr_pkg::Q_W-1:0]           q;
    logic [rpvr_pkg::TURN_W-1:0]        q45;
    logic [rpvr_pkg::TURN_W-1:0]        rem_full;
    logic [rpvr_pkg::REM_W-1:0]         rem;
    logic [rpvr_pkg::LOW_W-1:0]         low;
    logic [rpvr_pkg::PHASE_W-1:0]       phase_next;

    // Fold the angle into one turn
    always_comb
    begin
        if (deg < 0)
        begin
            s1 = deg + rpvr_pkg::FULL_TURN;
        end
        else if (deg >= rpvr_pkg::FULL_TURN)
        begin
            s1 = deg - rpvr_pkg::FULL_TURN;
        end
        else
        begin
            s1 = deg;
        end
        s2 = (s1 < 0) ? s1 + rpvr_pkg::FULL_TURN : s1;
    end

    // Quotient by 45 through the reciprocal, then the sub-step from the remainder
    assign prod_next = 51'(r_reg) * 51'(rpvr_pkg::RECIP_45);
    assign q         = prod_reg[rpvr_pkg::RECIP_SHIFT+rpvr_pkg::Q_W-1:rpvr_pkg::RECIP_SHIFT];
    assign q45       = rpvr_pkg::TURN_W'(q) * rpvr_pkg::DIV_45;
    assign rem_full  = r2_reg - q45;
    assign rem       = rem_full[rpvr_pkg::REM_W-1:0];

    always_comb
    begin
        low = rpvr_pkg::LOW_W'(rem) * rpvr_pkg::LOW_STEP;
        if (rem >= rpvr_pkg::LOW_KNEE2)
        begin
            low = low + 13'd2;
        end
        else if (rem >= rpvr_pkg::LOW_KNEE1)
        begin
            low = low + 13'd1;
        end
        phase_next = {q, low};
    end

    // Advance three stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg    <= s2[rpvr_pkg::TURN_W-1:0];
            prod_reg <= prod_next;
            r2_reg   <= r_reg;
            phase    <= phase_next;
        end
    end

endmodule

FILE: design/rpvr_rot_cell.sv
module rpvr_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                                clk,
    input  logic                                adv,
    input  logic signed [rpvr_pkg::CW-1:0]      x_in,
    input  logic signed [rpvr_pkg::CW-1:0]      y_in,
    input  logic signed [rpvr_pkg::ZW-1:0]      z_in,
    output logic signed [rpvr_pkg::CW-1:0]      x_out,
    output logic signed [rpvr_pkg::CW-1:0]      y_out,
    output logic signed [rpvr_pkg::ZW-1:0]      z_out
);

    logic signed [rpvr_pkg::CW-1:0] xs;
    logic signed [rpvr_pkg::CW-1:0] ys;
    logic signed [rpvr_pkg::ZW-1:0] at;

    assign xs = x_in >>> STEP;
    assign ys = y_in >>> STEP;
    assign at = signed'({2'b00, rpvr_pkg::ATAN_TAB[STEP]});

    // Turn toward zero residual angle
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (!z_in[rpvr_pkg::ZW-1])
            begin
                x_out <= x_in - ys;
                y_out <= y_in + xs;
                z_out <= z_in - at;
            end
            else
            begin
                x_out <= x_in + ys;
                y_out <= y_in - xs;
                z_out <= z_in + at;
            end
        end
    end

endmodule

FILE: design/rpvr_vec_cell.sv
module rpvr_vec_cell #(
    parameter int STEP = 0
) (
    input  logic                                 clk,
    input  logic                                 adv,
    input  logic signed [rpvr_pkg::VW-1:0]       x_in,
    input  logic signed [rpvr_pkg::VW-1:0]       y_in,
    input  logic [rpvr_pkg::PHASE_W-1:0]         z_in,
    output logic signed [rpvr_pkg::VW-1:0]       x_out,
    output logic signed [rpvr_pkg::VW-1:0]       y_out,
    output logic [rpvr_pkg::PHASE_W-1:0]         z_out
);

    logic signed [rpvr_pkg::VW-1:0] xs;
    logic signed [rpvr_pkg::VW-1:0] ys;
    logic                           y_pos;

    assign xs    = x_in >>> STEP;
    assign ys    = y_in >>> STEP;
    assign y_pos = !y_in[rpvr_pkg::VW-1] && (|y_in);

    // Drive y toward zero and collect the angle
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (y_pos)
            begin
                x_out <= x_in + ys;
                y_out <= y_in - xs;
                z_out <= z_in + rpvr_pkg::ATAN_TAB[STEP];
            end
            else
            begin
                x_out <= x_in - ys;
                y_out <= y_in + xs;
                z_out <= z_in - rpvr_pkg::ATAN_TAB[STEP];
            end
        end
    end

endmodule

FILE: design/rpvr_sincos.sv
module rpvr_sincos (
    input  logic                                 clk,
    input  logic                                 adv,
    input  logic [rpvr_pkg::PHASE_W-1:0]         phase,
    output logic signed [rpvr_pkg::SCW-1:0]      sin_q,
    output logic signed [rpvr_pkg::SCW-1:0]      cos_q
);

    localparam logic signed [rpvr_pkg::ZW-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [rpvr_pkg::ZW-1:0] HALF    = 34'sd2147483648;

    logic signed [rpvr_pkg::ZW-1:0] zs;
    logic signed [rpvr_pkg::ZW-1:0] z_fold;
    logic                           neg_next;
    logic signed [rpvr_pkg::ZW-1:0] z_pre_reg;
    logic                           neg_reg [0:rpvr_pkg::ITERS];
    logic signed [rpvr_pkg::CW-1:0] x_w [0:rpvr_pkg::ITERS];
    logic signed [rpvr_pkg::CW-1:0] y_w [0:rpvr_pkg::ITERS];
    logic signed [rpvr_pkg::ZW-1:0] z_w [0:rpvr_pkg::ITERS];
    logic signed [rpvr_pkg::CW-1:0] x_fin;
    logic signed [rpvr_pkg::CW-1:0] y_fin;

    // Fold the phase into the right half plane
    always_comb
    begin
        zs       = signed'({{2{phase[rpvr_pkg::PHASE_W-1]}}, phase});
        z_fold   = zs;
        neg_next = 1'b0;
        if (zs > QUARTER)
        begin
            z_fold   = zs - HALF;
            neg_next = 1'b1;
        end
        else if (zs < -QUARTER)
        begin
            z_fold   = zs + HALF;
            neg_next = 1'b1;
        end
    end

    // Hold the fold flag alongside the cells
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_pre_reg  <= z_fold;
            neg_reg[0] <= neg_next;
            for (int k = 1; k <= rpvr_pkg::ITERS; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign x_w[0] = rpvr_pkg::INV_GAIN;
    assign y_w[0] = '0;
    assign z_w[0] = z_pre_reg;

    // Chain of rotation cells
    for (genvar i = 0; i < rpvr_pkg::ITERS; i++)
    begin : g_cell
        rpvr_rot_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .adv   (adv),
            .x_in  (x_w[i]),
            .y_in  (y_w[i]),
            .z_in  (z_w[i]),
            .x_out (x_w[i+1]),
            .y_out (y_w[i+1]),
            .z_out (z_w[i+1])
        );
    end

    // Undo the fold
    assign x_fin = neg_reg[rpvr_pkg::ITERS] ? -x_w[rpvr_pkg::ITERS] : x_w[rpvr_pkg::ITERS];
    assign y_fin = neg_reg[rpvr_pkg::ITERS] ? -y_w[rpvr_pkg::ITERS] : y_w[rpvr_pkg::ITERS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_q <= x_fin[rpvr_pkg::SCW-1:0];
            sin_q <= y_fin[rpvr_pkg::SCW-1:0];
        end
    end

endmodule

FILE: design/rotated_pole_vector_rotation.sv
// Rotates one (u, v) vector per beat between geographic east/north and a grid
// whose pole sits at (pole_longitude, pole_latitude). The block takes one beat
// every clock cycle while its skid register is empty; the result of a beat
// passes through the cell chains: three 24-step CORDIC rotation chains for
// the point and pole angles, a 24-step vectoring chain for the local angle, a
// fourth rotation chain for its sine and cosine, and the multiplier stages in
// between. Ready falls the cycle after a finished beat meets a stalled sink and
// parks in the skid register, and stays low until that beat moves into the
// output register, so a sink stall can hold off the input. Write the pole
// registers only while no beat is in flight. When the local angle is undefined
// near the pole, degenerate is set and the vector passes through unchanged.
`include "assert_macros.svh"

module rotated_pole_vector_rotation (
    input  logic         clk,
    input  logic         rst_n,
    rpvr_in_if.sink      item,
    rpvr_out_if.source   result,
    rpvr_cfg_if.sink     cfg
);

    localparam int LAST = rpvr_pkg::ST_LAST;

    // Configuration registers
    logic signed [rpvr_pkg::LON_W-1:0] pole_lon_reg;
    logic signed [rpvr_pkg::LAT_W-1:0] pole_lat_reg;

    // Pipeline control
    logic                 adv;
    logic                 vld_reg [1:LAST];
    rpvr_pkg::side_t      side_reg [1:LAST];
    logic                 dg_reg [rpvr_pkg::ST_V0:LAST];

    // Angles into the phase units
    logic signed [rpvr_pkg::DEG_W-1:0] deg_plat;
    logic signed [rpvr_pkg::DEG_W-1:0] deg_lat;
    logic signed [rpvr_pkg::DEG_W-1:0] deg_dlon;
    logic [rpvr_pkg::PHASE_W-1:0]      ph_plat;
    logic [rpvr_pkg::PHASE_W-1:0]      ph_lat;
    logic [rpvr_pkg::PHASE_W-1:0]      ph_dlon;

    // Trig of the three angles
    logic signed [rpvr_pkg::SCW-1:0]   sp;
    logic signed [rpvr_pkg::SCW-1:0]   cp;
    logic signed [rpvr_pkg::SCW-1:0]   sl;
    logic signed [rpvr_pkg::SCW-1:0]   cl;
    logic signed [rpvr_pkg::SCW-1:0]   sd;
    logic signed [rpvr_pkg::SCW-1:0]   cd;

    // a and b
    logic signed [63:0]                p1_reg;
    logic signed [63:0]                p2_reg;
    logic signed [63:0]                p3_reg;
    logic signed [rpvr_pkg::SCW-1:0]   cd_reg;
    logic signed [rpvr_pkg::AB_W-1:0]  a1_reg;
    logic signed [rpvr_pkg::AB_W-1:0]  b1_reg;
    logic signed [63:0]                t_reg;
    logic signed [rpvr_pkg::AB_W-1:0]  a_reg;
    logic signed [rpvr_pkg::AB_W-1:0]  b_reg;

    // Degenerate test
    logic                              a_small;
    logic                              b_small;
    logic signed [14:0]                a15;
    logic signed [14:0]                b15;
    logic signed [29:0]                asq;
    logic signed [29:0]                bsq;
    logic [30:0]                       msum;
    logic                              dg_next;

    // Vectoring chain
    logic signed [rpvr_pkg::VW-1:0]    vx0;
    logic signed [rpvr_pkg::VW-1:0]    vy0;
    logic signed [rpvr_pkg::VW-1:0]    vx_w [0:rpvr_pkg::ITERS];
    logic signed [rpvr_pkg::VW-1:0]    vy_w [0:rpvr_pkg::ITERS];
    logic [rpvr_pkg::PHASE_W-1:0]      vz_w [0:rpvr_pkg::ITERS];
    logic signed [rpvr_pkg::VW-1:0]    vx0_reg;
    logic signed [rpvr_pkg::VW-1:0]    vy0_reg;
    logic [rpvr_pkg::PHASE_W-1:0]      vz0_reg;

    // Final rotation
    logic signed [rpvr_pkg::SCW-1:0]   s2;
    logic signed [rpvr_pkg::SCW-1:0]   c2;
    logic signed [63:0]                pcu_reg;
    logic signed [63:0]                psv_reg;
    logic signed [63:0]                pcv_reg;
    logic signed [63:0]                psu_reg;
    logic signed [64:0]                su;
    logic signed [64:0]                sv;
    logic signed [rpvr_pkg::VEC_W-1:0] res_u;
    logic signed [rpvr_pkg::VEC_W-1:0] res_v;
    logic                              res_dg;
    logic                              res_vld;

    // Output register and skid
    logic                              out_vld_reg;
    logic signed [rpvr_pkg::VEC_W-1:0] out_u_reg;
    logic signed [rpvr_pkg::VEC_W-1:0] out_v_reg;
    logic                              out_dg_reg;
    logic                              skid_vld_reg;
    logic signed [rpvr_pkg::VEC_W-1:0] skid_u_reg;
    logic signed [rpvr_pkg::VEC_W-1:0] skid_v_reg;
    logic                              skid_dg_reg;

    function automatic logic signed [rpvr_pkg::VEC_W-1:0] sat_round(
        input logic signed [64:0] p
    );
        logic signed [64:0] rnd;
        logic signed [34:0] r;
        rnd = p + 65'sd536870912;
        r   = signed'(rnd[64:30]);
        if (r > 35'sd2147483647)
        begin
            sat_round = 32'sh7FFFFFFF;
        end
        else if (r < -35'sd2147483648)
        begin
            sat_round = 32'sh80000000;
        end
        else
        begin
            sat_round = r[31:0];
        end
    endfunction

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_lon_reg <= rpvr_pkg::POLE_LON_RST;
            pole_lat_reg <= rpvr_pkg::POLE_LAT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (rpvr_pkg::cfg_reg_t'(cfg.index))
                rpvr_pkg::REG_POLE_LON: pole_lon_reg <= signed'(cfg.data[rpvr_pkg::LON_W-1:0]);
                rpvr_pkg::REG_POLE_LAT: pole_lat_reg <= signed'(cfg.data[rpvr_pkg::LAT_W-1:0]);
                default: ;
            endcase
        end
    end

    // The pipe moves whenever the skid is free
    assign adv        = !skid_vld_reg;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[1] <= item.valid;
            for (int k = 2; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Carry kind, u, v and the degenerate flag along
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= '{kind: item.kind, u: item.u_in, v: item.v_in};
            for (int k = 2; k <= LAST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            dg_reg[rpvr_pkg::ST_V0] <= dg_next;
            for (int k = rpvr_pkg::ST_V0 + 1; k <= LAST; k++)
            begin
                dg_reg[k] <= dg_reg[k-1];
            end
        end
    end

    // Angles for the phase units
    assign deg_plat = rpvr_pkg::DEG_W'(pole_lat_reg);
    assign deg_lat  = rpvr_pkg::DEG_W'(item.lat_deg);
    assign deg_dlon = rpvr_pkg::DEG_W'(pole_lon_reg) - rpvr_pkg::DEG_W'(item.lon_deg);

    rpvr_phase u_ph_plat (.clk(clk), .adv(adv), .deg(deg_plat), .phase(ph_plat));
    rpvr_phase u_ph_lat  (.clk(clk), .adv(adv), .deg(deg_lat),  .phase(ph_lat));
    rpvr_phase u_ph_dlon (.clk(clk), .adv(adv), .deg(deg_dlon), .phase(ph_dlon));

    rpvr_sincos u_sc_plat (.clk(clk), .adv(adv), .phase(ph_plat), .sin_q(sp), .cos_q(cp));
    rpvr_sincos u_sc_lat  (.clk(clk), .adv(adv), .phase(ph_lat),  .sin_q(sl), .cos_q(cl));
    rpvr_sincos u_sc_dlon (.clk(clk), .adv(adv), .phase(ph_dlon), .sin_q(sd), .cos_q(cd));

    // Form a and b over three stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= cp * sd;
            p2_reg <= cl * sp;
            p3_reg <= sl * cp;
            cd_reg <= cd;
            a1_reg <= signed'(p1_reg[63:30]);
            b1_reg <= signed'(p2_reg[63:30]);
            t_reg  <= signed'(p3_reg[61:30]) * cd_reg;
            a_reg  <= a1_reg;
            b_reg  <= b1_reg - signed'(t_reg[63:30]);
        end
    end

    // Flag a magnitude below one part in 2^16
    assign a_small = (a_reg >= -34'sd16384) && (a_reg <= 34'sd16383);
    assign b_small = (b_reg >= -34'sd16384) && (b_reg <= 34'sd16383);
    assign a15     = signed'(a_reg[14:0]);
    assign b15     = signed'(b_reg[14:0]);
    assign asq     = a15 * a15;
    assign bsq     = b15 * b15;
    assign msum    = {1'b0, asq} + {1'b0, bsq};
    assign dg_next = a_small && b_small && (msum < 31'd268435456);

    // Turn (b, a) into the right half plane before vectoring
    assign vx0 = rpvr_pkg::VW'(b_reg);
    assign vy0 = rpvr_pkg::VW'(a_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (b_reg[rpvr_pkg::AB_W-1])
            begin
                vx0_reg <= -vx0;
                vy0_reg <= -vy0;
                vz0_reg <= 32'h80000000;
            end
            else
            begin
                vx0_reg <= vx0;
                vy0_reg <= vy0;
                vz0_reg <= '0;
            end
        end
    end

    assign vx_w[0] = vx0_reg;
    assign vy_w[0] = vy0_reg;
    assign vz_w[0] = vz0_reg;

    // Chain of vectoring cells
    for (genvar i = 0; i < rpvr_pkg::ITERS; i++)
    begin : g_vec
        rpvr_vec_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .adv   (adv),
            .x_in  (vx_w[i]),
            .y_in  (vy_w[i]),
            .z_in  (vz_w[i]),
            .x_out (vx_w[i+1]),
            .y_out (vy_w[i+1]),
            .z_out (vz_w[i+1])
        );
    end

    rpvr_sincos u_sc_rot (
        .clk   (clk),
        .adv   (adv),
        .phase (vz_w[rpvr_pkg::ITERS]),
        .sin_q (s2),
        .cos_q (c2)
    );

    // Rotation products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pcu_reg <= c2 * signed'(side_reg[rpvr_pkg::ST_SC2].u);
            psv_reg <= s2 * signed'(side_reg[rpvr_pkg::ST_SC2].v);
            pcv_reg <= c2 * signed'(side_reg[rpvr_pkg::ST_SC2].v);
            psu_reg <= s2 * signed'(side_reg[rpvr_pkg::ST_SC2].u);
        end
    end

    // Sum, round, saturate, or pass through near the pole
    always_comb
    begin
        if (side_reg[LAST].kind)
        begin
            su = 65'(pcu_reg) - 65'(psv_reg);
            sv = 65'(psu_reg) + 65'(pcv_reg);
        end
        else
        begin
            su = 65'(pcu_reg) + 65'(psv_reg);
            sv = 65'(pcv_reg) - 65'(psu_reg);
        end
        res_dg = dg_reg[LAST];
        if (res_dg)
        begin
            res_u = signed'(side_reg[LAST].u);
            res_v = signed'(side_reg[LAST].v);
        end
        else
        begin
            res_u = sat_round(su);
            res_v = sat_round(sv);
        end
    end

    assign res_vld = adv && vld_reg[LAST];

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && result.ready)
        begin
            if (skid_vld_reg)
            begin
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= res_vld;
            end
        end
        else if (!out_vld_reg)
        begin
            out_vld_reg <= res_vld;
        end
        else if (res_vld)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((out_vld_reg && result.ready) || !out_vld_reg)
        begin
            if (skid_vld_reg)
            begin
                out_u_reg  <= skid_u_reg;
                out_v_reg  <= skid_v_reg;
                out_dg_reg <= skid_dg_reg;
            end
            else
            begin
                out_u_reg  <= res_u;
                out_v_reg  <= res_v;
                out_dg_reg <= res_dg;
            end
        end
        if (res_vld)
        begin
            skid_u_reg  <= res_u;
            skid_v_reg  <= res_v;
            skid_dg_reg <= res_dg;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.u_out      = out_u_reg;
    assign result.v_out      = out_v_reg;
    assign result.degenerate = out_dg_reg;

    `ASSERT_SAME(a_skid_behind_out, skid_vld_reg, out_vld_reg, "skid holds a beat with the output empty")
    `ASSERT_NEXT(a_skid_drains, skid_vld_reg && result.ready, !skid_vld_reg, "skid did not drain")
    `ASSERT_NEXT(a_out_fills, !out_vld_reg && res_vld, out_vld_reg, "finished beat lost at output")

endmodule
